FILE: hdl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// Sensor frame deframer package
// Shared constants, result codes and the configuration bundle.
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 40;

  localparam logic [CfgIdxW-1:0] CFG_PREAMBLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd2;

  localparam logic [7:0] DefaultPreamble = 8'd250;
  localparam logic [15:0] DefaultSyncLimit = 16'd200;
  localparam logic [15:0] DefaultMaxLen = 16'd2048;
  localparam logic [7:0] ExtLenMark = 8'hFF;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_GOOD = 3'd1;
  localparam logic [2:0] KIND_BADSUM = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_TOOLONG = 3'd4;

  typedef struct packed {
    logic [7:0] preamble_value;
    logic [15:0] sync_limit;
    logic [15:0] max_payload_len;
  } cfg_t;

endpackage

FILE: hdl/sfd_cfg_regs.sv
// ---------------------------------------------------------------------------
// Sensor frame deframer configuration registers
// Holds the preamble, sync limit and maximum payload length.
// ---------------------------------------------------------------------------
module sfd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sfd_pkg::CfgDataW-1:0] cfg_data,
  output sfd_pkg::cfg_t                cfg
);
  import sfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_value <= DefaultPreamble;
      cfg.sync_limit <= DefaultSyncLimit;
      cfg.max_payload_len <= DefaultMaxLen;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PREAMBLE:   cfg.preamble_value <= cfg_data[7:0];
        CFG_SYNC_LIMIT: cfg.sync_limit <= cfg_data;
        CFG_MAX_LEN:    cfg.max_payload_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/sfd_parser.sv
// ---------------------------------------------------------------------------
// Sensor frame deframer parser
// Frame state machine with a registered result stage.
// ---------------------------------------------------------------------------
module sfd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  sfd_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_kind,
  output logic [7:0]                    out_data_byte,
  output logic [7:0]                    out_msg_id,
  output logic [7:0]                    out_bus_id,
  output logic [15:0]                   out_byte_index,
  output logic                          out_last
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_BID, PH_MID, PH_LEN, PH_EXT_HI, PH_EXT_LO, PH_DATA, PH_CKSUM
  } phase_t;

  phase_t phase, phase_next;
  logic [15:0] sync_count, sync_count_next, sync_inc;
  logic [7:0] frame_bus_id, frame_bus_id_next;
  logic [7:0] frame_msg_id, frame_msg_id_next;
  logic [15:0] payload_length, payload_length_next, len_val;
  logic [15:0] payload_index, payload_index_next, index_inc;
  logic [7:0] running_sum, running_sum_next, sum_add;
  logic accept, res_valid;
  logic [2:0] res_kind;
  logic [7:0] res_data;
  logic [15:0] res_index;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign sum_add = running_sum + rx_byte;
  assign sync_inc = sync_count + 16'd1;
  assign index_inc = payload_index + 16'd1;
  assign len_val = (phase == PH_EXT_LO) ? {payload_length[15:8], rx_byte}
                                        : {8'd0, rx_byte};

  always_comb begin
    phase_next = phase;
    sync_count_next = sync_count;
    frame_bus_id_next = frame_bus_id;
    frame_msg_id_next = frame_msg_id;
    payload_length_next = payload_length;
    payload_index_next = payload_index;
    running_sum_next = (phase == PH_HUNT) ? running_sum : sum_add;
    res_valid = 1'b0;
    res_kind = KIND_PAYLOAD;
    res_data = 8'd0;
    res_index = 16'd0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == cfg.preamble_value) begin
          sync_count_next = 16'd0;
          running_sum_next = 8'd0;
          phase_next = PH_BID;
        end else if (sync_inc >= cfg.sync_limit) begin
          sync_count_next = 16'd0;
          res_valid = 1'b1;
          res_kind = KIND_TIMEOUT;
        end else begin
          sync_count_next = sync_inc;
        end
      end
      PH_BID: begin
        frame_bus_id_next = rx_byte;
        phase_next = PH_MID;
      end
      PH_MID: begin
        frame_msg_id_next = rx_byte;
        phase_next = PH_LEN;
      end
      PH_EXT_HI: begin
        payload_length_next = {rx_byte, 8'd0};
        phase_next = PH_EXT_LO;
      end
      PH_LEN, PH_EXT_LO: begin
        if (phase == PH_LEN && rx_byte == ExtLenMark) begin
          phase_next = PH_EXT_HI;
        end else begin
          payload_length_next = len_val;
          if (len_val > cfg.max_payload_len) begin
            res_valid = 1'b1;
            res_kind = KIND_TOOLONG;
            res_index = len_val;
            phase_next = PH_HUNT;
            sync_count_next = 16'd0;
          end else begin
            payload_index_next = 16'd0;
            phase_next = (len_val == 16'd0) ? PH_CKSUM : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_valid = 1'b1;
        res_kind = KIND_PAYLOAD;
        res_data = rx_byte;
        res_index = payload_index;
        payload_index_next = index_inc;
        if (index_inc >= payload_length) begin
          phase_next = PH_CKSUM;
        end
      end
      PH_CKSUM: begin
        res_valid = 1'b1;
        res_kind = (sum_add == 8'd0) ? KIND_GOOD : KIND_BADSUM;
        res_index = payload_length;
        phase_next = PH_HUNT;
        sync_count_next = 16'd0;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      sync_count <= 16'd0;
      frame_bus_id <= 8'd0;
      frame_msg_id <= 8'd0;
      payload_length <= 16'd0;
      payload_index <= 16'd0;
      running_sum <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        sync_count <= sync_count_next;
        frame_bus_id <= frame_bus_id_next;
        frame_msg_id <= frame_msg_id_next;
        payload_length <= payload_length_next;
        payload_index <= payload_index_next;
        running_sum <= running_sum_next;
      end
      if (accept && res_valid) begin
        out_valid <= 1'b1;
        out_kind <= res_kind;
        out_data_byte <= res_data;
        out_msg_id <= (res_kind == KIND_TIMEOUT) ? 8'd0 : frame_msg_id_next;
        out_bus_id <= (res_kind == KIND_TIMEOUT) ? 8'd0 : frame_bus_id_next;
        out_byte_index <= res_index;
        out_last <= (res_kind != KIND_PAYLOAD);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/sensor_frame_deframer_core.sv
// ---------------------------------------------------------------------------
// Sensor frame deframer core
// Output: a result appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the output is not stalled, set by the single registered result stage.
// Reset: synchronous, clears the frame state to preamble hunting, restores
// the default configuration and drops any pending result.
// ---------------------------------------------------------------------------
module sensor_frame_deframer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sfd_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // data_byte[7:0], msg_id[15:8], bus_id[23:16], byte_index[39:24]
  output logic [sfd_pkg::OutDataW-1:0]  m_tdata,
  output logic [2:0]                    m_tuser,   // kind
  output logic                          m_tlast
);
  import sfd_pkg::*;

  cfg_t cfg;
  logic [7:0] data_byte, msg_id, bus_id;
  logic [15:0] byte_index;

  sfd_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  sfd_parser u_parser (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready), .rx_byte(s_tdata),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_kind(m_tuser), .out_data_byte(data_byte), .out_msg_id(msg_id),
    .out_bus_id(bus_id), .out_byte_index(byte_index), .out_last(m_tlast)
  );

  assign m_tdata = {byte_index, bus_id, msg_id, data_byte};

  a_payload_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PAYLOAD |-> !m_tlast)
    else $error("payload item marked last");

  a_end_has_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("frame end item malformed");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_TIMEOUT |-> m_tdata == '0)
    else $error("timeout item carries frame fields");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

FILE: verif/sensor_frame_deframer_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sensor frame deframer core testbench
// Feeds received bytes into the deframer and predicts every result with an
// independent model of the frame parser. Directed tests cover the frame
// kinds, sync timeouts, length limits and register writes, and one long
// output hold-off that backs up the input. Random traffic then runs under
// several register settings, with gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module sensor_frame_deframer_core_test;
  import sfd_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 600000;

  typedef enum logic [2:0] {
    SEEK_PREAMBLE,
    GET_BUS_ID,
    GET_MSG_ID,
    GET_LEN,
    GET_EXT_HI,
    GET_EXT_LO,
    GET_PAYLOAD,
    GET_CHECKSUM
  } rx_phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] msg_id;
    logic [7:0] bus_id;
    logic [15:0] byte_index;
    logic last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  logic [7:0] cfg_preamble = DefaultPreamble;
  logic [15:0] cfg_sync_limit = DefaultSyncLimit;
  logic [15:0] cfg_max_len = DefaultMaxLen;

  rx_phase_t rx_phase = SEEK_PREAMBLE;
  logic [15:0] hunt_count = '0;
  logic [7:0] cur_bus_id = '0;
  logic [7:0] cur_msg_id = '0;
  logic [15:0] cur_len = '0;
  logic [15:0] cur_index = '0;
  logic [7:0] cur_sum = '0;

  frame_result_t results_due[$];
  frame_result_t oldest;
  int unsigned failures = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  int unsigned rx_hold_cycles = 0;

  sensor_frame_deframer_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    bit emit;
    bit len_known;
    r = '0;
    emit = 1'b0;
    len_known = 1'b0;
    if (rx_phase != SEEK_PREAMBLE) cur_sum += b;
    case (rx_phase)
      SEEK_PREAMBLE: begin
        if (b == cfg_preamble) begin
          hunt_count = '0;
          cur_sum = '0;
          rx_phase = GET_BUS_ID;
        end else begin
          hunt_count++;
          if (hunt_count >= cfg_sync_limit) begin
            hunt_count = '0;
            r.kind = KIND_TIMEOUT;
            r.last = 1'b1;
            emit = 1'b1;
          end
        end
      end
      GET_BUS_ID: begin
        cur_bus_id = b;
        rx_phase = GET_MSG_ID;
      end
      GET_MSG_ID: begin
        cur_msg_id = b;
        rx_phase = GET_LEN;
      end
      GET_LEN: begin
        if (b == ExtLenMark) begin
          rx_phase = GET_EXT_HI;
        end else begin
          cur_len = {8'h00, b};
          len_known = 1'b1;
        end
      end
      GET_EXT_HI: begin
        cur_len = {b, 8'h00};
        rx_phase = GET_EXT_LO;
      end
      GET_EXT_LO: begin
        cur_len[7:0] = b;
        len_known = 1'b1;
      end
      GET_PAYLOAD: begin
        r.kind = KIND_PAYLOAD;
        r.data_byte = b;
        r.msg_id = cur_msg_id;
        r.bus_id = cur_bus_id;
        r.byte_index = cur_index;
        emit = 1'b1;
        cur_index++;
        if (cur_index >= cur_len) rx_phase = GET_CHECKSUM;
      end
      default: begin
        r.kind = (cur_sum == 8'h00) ? KIND_GOOD : KIND_BADSUM;
        r.msg_id = cur_msg_id;
        r.bus_id = cur_bus_id;
        r.byte_index = cur_len;
        r.last = 1'b1;
        emit = 1'b1;
        rx_phase = SEEK_PREAMBLE;
        hunt_count = '0;
      end
    endcase
    if (len_known) begin
      if (cur_len > cfg_max_len) begin
        r.kind = KIND_TOOLONG;
        r.msg_id = cur_msg_id;
        r.bus_id = cur_bus_id;
        r.byte_index = cur_len;
        r.last = 1'b1;
        emit = 1'b1;
        rx_phase = SEEK_PREAMBLE;
        hunt_count = '0;
      end else begin
        cur_index = '0;
        rx_phase = (cur_len == 16'd0) ? GET_CHECKSUM : GET_PAYLOAD;
      end
    end
    if (emit) results_due.push_back(r);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d, tdata %h", m_tuser, m_tdata);
        failures++;
      end else begin
        oldest = results_due.pop_front();
        check_field("kind", oldest.kind, m_tuser);
        check_field("data_byte", oldest.data_byte, m_tdata[7:0]);
        check_field("msg_id", oldest.msg_id, m_tdata[15:8]);
        check_field("bus_id", oldest.bus_id, m_tdata[23:16]);
        check_field("byte_index", oldest.byte_index, m_tdata[39:24]);
        check_field("last", oldest.last, m_tlast);
      end
    end
  end

  initial begin
    int unsigned held;
    int unsigned stall;
    forever begin
      if (rx_hold_cycles != 0) begin
        m_tready <= 1'b0;
        held = 0;
        while (held < rx_hold_cycles) begin
          @(posedge clk);
          held++;
        end
        rx_hold_cycles = 0;
      end else if (rx_stalls) begin
        stall = pick_gap();
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == cfg_preamble) b ^= 8'h01;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic [7:0] bid, input logic [7:0] mid,
                            input logic [15:0] plen, input bit ext, input bit bad_sum,
                            input int unsigned keep);
    logic [7:0] frame[$];
    logic [7:0] sum;
    int unsigned count;
    frame.push_back(cfg_preamble);
    frame.push_back(bid);
    frame.push_back(mid);
    if (ext) begin
      frame.push_back(ExtLenMark);
      frame.push_back(plen[15:8]);
      frame.push_back(plen[7:0]);
    end else begin
      frame.push_back(plen[7:0]);
    end
    if (plen <= cfg_max_len) begin
      repeat (plen) frame.push_back(8'($urandom));
      sum = 8'h00;
      foreach (frame[i]) if (i > 0) sum += frame[i];
      sum = -sum;
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      frame.push_back(sum);
    end
    count = (keep != 0 && keep < frame.size()) ? keep : frame.size();
    for (int i = 0; i < count; i++) send_byte(frame[i]);
  endtask

  // Lets the block finish all outstanding work so registers can be written.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PREAMBLE: cfg_preamble = val[7:0];
      CFG_SYNC_LIMIT: cfg_sync_limit = val;
      CFG_MAX_LEN: cfg_max_len = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] pre, input logic [15:0] sync_lim,
                            input logic [15:0] max_len);
    write_reg(CFG_PREAMBLE, {8'h00, pre});
    write_reg(CFG_SYNC_LIMIT, sync_lim);
    write_reg(CFG_MAX_LEN, max_len);
  endtask

  task automatic test_default_frames();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 8'hFF, 16'd1, 1'b0, 1'b0, 0);
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0, 1'b1, 0);
    send_frame(8'h12, 8'h34, 16'd2, 1'b1, 1'b0, 0);
    drain();
  endtask

  task automatic test_sync_timeout();
    set_config(DefaultPreamble, 16'd3, DefaultMaxLen);
    send_noise(3);
    send_noise(2);
    send_frame(8'h5A, 8'hA5, 16'd0, 1'b0, 1'b0, 0);
    send_noise(3);
    drain();
    write_reg(CFG_SYNC_LIMIT, 16'd0);
    send_noise(2);
    drain();
  endtask

  task automatic test_length_limits();
    set_config(8'hFF, DefaultSyncLimit, 16'd2);
    send_frame(8'h01, 8'h02, 16'd2, 1'b0, 1'b0, 0);
    send_frame(8'h03, 8'h04, 16'd3, 1'b0, 1'b0, 0);
    send_frame(8'h05, 8'h06, 16'hFFFF, 1'b1, 1'b0, 0);
    drain();
    write_reg(CFG_MAX_LEN, 16'd0);
    send_frame(8'h07, 8'h08, 16'd0, 1'b0, 1'b0, 0);
    send_frame(8'h09, 8'h0A, 16'd1, 1'b0, 1'b0, 0);
    drain();
    set_config(8'h00, 16'hFFFF, 16'hFFFF);
    send_frame(8'h80, 8'h7F, 16'd1, 1'b0, 1'b0, 0);
    send_frame(8'hC3, 8'h3C, 16'd3, 1'b1, 1'b1, 0);
    // The length limit is lowered after the header has started.
    send_byte(cfg_preamble);
    send_byte(8'h11);
    send_byte(8'h22);
    drain();
    write_reg(CFG_MAX_LEN, 16'd1);
    send_byte(8'h02);
    drain();
  endtask

  task automatic test_unknown_register();
    set_config(DefaultPreamble, DefaultSyncLimit, DefaultMaxLen);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_frame(8'h44, 8'h55, 16'd2, 1'b0, 1'b0, 0);
    drain();
  endtask

  task automatic test_output_backpressure();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    rx_hold_cycles = 150;
    send_frame(8'h66, 8'h77, 16'd40, 1'b0, 1'b0, 0);
    send_frame(8'h88, 8'h99, 16'd5, 1'b1, 1'b0, 0);
    drain();
  endtask

  task automatic send_random_frame();
    logic [15:0] plen;
    int unsigned r;
    int unsigned hdr;
    int unsigned keep;
    bit ext;
    if ($urandom_range(0, 99) < 30) send_noise($urandom_range(1, 4));
    r = $urandom_range(0, 99);
    if (r < 10 && cfg_max_len != 16'hFFFF)
      plen = 16'(cfg_max_len + 1 + $urandom_range(0, 65534 - cfg_max_len));
    else if (r < 25)
      plen = 16'($urandom_range(13, 40));
    else
      plen = 16'($urandom_range(0, 12));
    ext = (plen > 16'd254) || ($urandom_range(0, 3) == 0);
    hdr = ext ? 6 : 4;
    keep = 0;
    if (plen <= cfg_max_len && cfg_max_len <= 16'd255 && $urandom_range(0, 99) < 8)
      keep = $urandom_range(hdr, hdr + plen);
    send_frame(8'($urandom), 8'($urandom), plen, ext, $urandom_range(0, 99) < 15, keep);
    if (plen > cfg_max_len) send_noise($urandom_range(0, 3));
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned stage_start;
    int unsigned stage;
    start = bytes_sent;
    stage = 0;
    while (bytes_sent - start < 550) begin
      drain();
      case (stage % 5)
        0: begin
          set_config(DefaultPreamble, DefaultSyncLimit, DefaultMaxLen);
          tx_gaps = 1'b1;
          rx_stalls = 1'b1;
        end
        1: begin
          set_config(8'h00, 16'd1, 16'd0);
          tx_gaps = 1'b1;
          rx_stalls = 1'b0;
        end
        2: begin
          set_config(8'hFF, 16'hFFFF, 16'hFFFF);
          tx_gaps = 1'b0;
          rx_stalls = 1'b0;
        end
        3: begin
          set_config(8'($urandom), 16'($urandom_range(2, 12)), 16'($urandom_range(0, 40)));
          tx_gaps = 1'b0;
          rx_stalls = 1'b1;
        end
        default: begin
          set_config(8'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom));
          tx_gaps = 1'b1;
          rx_stalls = 1'b1;
        end
      endcase
      stage_start = bytes_sent;
      while (bytes_sent - stage_start < 110) send_random_frame();
      stage++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frames();
    test_sync_timeout();
    test_length_limits();
    test_unknown_register();
    test_output_backpressure();
    test_random_traffic();
    drain();
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
